// ===== rtl/psnr_pkg.sv =====
// psnr_pkg: shared constants and the controller/datapath command and status types
// for the psnr mse accumulator; no dependencies
package psnr_pkg;
   localparam int unsigned MaxBytesDefault = 16777216;
   localparam int unsigned CountWidth = 25;
   localparam int unsigned SumWidth = 40;
   localparam int unsigned PsnrWidth = 15;
   localparam int unsigned LogFrac = 28;
   localparam int unsigned LogWidth = 34;
   localparam logic [15:0] PeakSq = 16'd65025;
   localparam logic [25:0] TenLog10Two = 26'd50504453;

   typedef struct packed {
      logic accumulate;
      logic capture;
      logic log_start;
      logic log_step;
      logic log_second;
      logic finish;
   } psnr_cmd_type;

   typedef struct packed {
      logic log_done;
   } psnr_status_type;
endpackage

// ===== rtl/psnr_mse_accumulator.sv =====
// psnr_mse_accumulator: top level joining controller and datapath
// depends on psnr_pkg, psnr_ctrl, psnr_datapath
//
// usage: byte pairs enter on the req_ channel, one word per cycle while
// accumulating; tdata carries byte_a and byte_b, tlast closes an image
// every pair adds its squared difference, a pair count and a mismatch count
// counters stop at MAX_BYTES; later pairs are ignored but tlast still closes
// on the last word the sums are captured and cleared, then one shared log2
// unit runs twice (numerator 65025*count, then the sum), one bit a cycle
// rsp_tvalid rises after the last word is taken, once each log2 pass has run
// its start state and one step per fraction bit, and then the finishing state
// no input is taken from the last word until the result word is delivered
// the result word waits on rsp_ until rsp_tready; a stalled receiver holds
// the block, and the next image starts on the cycle after delivery
// synchronous reset clears the counters and returns to accumulation
module psnr_mse_accumulator #(
   parameter int unsigned MAX_BYTES = psnr_pkg::MaxBytesDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,  // byte_a [7:0], byte_b [15:8]
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // byte_count [24:0], mismatch_count [49:25], squared_error_sum [89:50],
   // identical [90], psnr_db_q8 [105:91], zero fill to 112
   output logic [111:0] rsp_tdata
);
   import psnr_pkg::*;

   psnr_cmd_type    cmd;
   psnr_status_type status;
   logic [CountWidth-1:0] byte_count, mismatch_count;
   logic [SumWidth-1:0]   sse;
   logic                  identical;
   logic [PsnrWidth-1:0]  psnr;

   psnr_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .status(status), .cmd(cmd)
   );

   psnr_datapath #(.MAX_BYTES(MAX_BYTES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .byte_a(req_tdata[7:0]), .byte_b(req_tdata[15:8]),
      .byte_count(byte_count), .mismatch_count(mismatch_count),
      .squared_error_sum(sse), .identical(identical), .psnr_db_q8(psnr)
   );

   // fields packed from the lowest bit up
   assign rsp_tdata = {6'd0, psnr, identical, sse, mismatch_count, byte_count};
endmodule

// ===== rtl/psnr_datapath.sv =====
// psnr_datapath: accumulators, shared log2 unit (one square-and-compare per cycle)
// and result register; depends on psnr_pkg
module psnr_datapath #(
   parameter int unsigned MAX_BYTES = psnr_pkg::MaxBytesDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  psnr_pkg::psnr_cmd_type         cmd,
   output psnr_pkg::psnr_status_type      status,
   input  logic [7:0]                     byte_a,
   input  logic [7:0]                     byte_b,
   output logic [psnr_pkg::CountWidth-1:0] byte_count,
   output logic [psnr_pkg::CountWidth-1:0] mismatch_count,
   output logic [psnr_pkg::SumWidth-1:0]   squared_error_sum,
   output logic                           identical,
   output logic [psnr_pkg::PsnrWidth-1:0]  psnr_db_q8
);
   import psnr_pkg::*;

   logic [CountWidth-1:0] pair_ff, pair_in, mis_ff, mis_in;
   logic [SumWidth-1:0]   sse_ff, sse_in;
   logic [SumWidth-1:0]   arg_ff, arg_in, sum_hold_ff, sum_hold_in;
   logic [CountWidth-1:0] cnt_hold_ff, cnt_hold_in;
   logic [32:0]           y_ff, y_in;
   logic [LogWidth-1:0]   r_ff, r_in, ln_ff, ln_in;
   logic [4:0]            bit_ff, bit_in;
   logic [8:0]            d;
   logic [15:0]           dsq;
   logic [65:0]           ysq;
   logic [32:0]           ynext;
   logic [5:0]            msb;
   logic [31:0]           norm;
   logic [LogWidth-1:0]   diff;
   logic [60:0]           prod;
   logic [16:0]           q;

   assign d = (byte_a > byte_b) ? {1'b0, byte_a - byte_b} : {1'b0, byte_b - byte_a};
   assign dsq = d[7:0] * d[7:0];
   assign ysq = y_ff * y_ff;
   assign ynext = ysq[63:31];

   always_comb begin
      msb = '0;
      for (int i = 0; i < SumWidth; i++) begin
         if (arg_ff[i]) begin
            msb = 6'(i);
         end
      end
      if (msb > 6'd31) begin
         norm = 32'(arg_ff >> (msb - 6'd31));
      end else begin
         norm = 32'(arg_ff << (6'd31 - msb));
      end
   end

   assign diff = ln_ff - r_ff;
   assign prod = diff * TenLog10Two;
   assign q = 17'((prod + (61'd1 << 43)) >> 44);

   always_comb begin
      pair_in = pair_ff;
      mis_in = mis_ff;
      sse_in = sse_ff;
      arg_in = arg_ff;
      sum_hold_in = sum_hold_ff;
      cnt_hold_in = cnt_hold_ff;
      y_in = y_ff;
      r_in = r_ff;
      ln_in = ln_ff;
      bit_in = bit_ff;
      if (cmd.accumulate && (pair_ff < CountWidth'(MAX_BYTES))) begin
         pair_in = pair_ff + 1'b1;
         sse_in = sse_ff + SumWidth'(dsq);
         if (d != 0) begin
            mis_in = mis_ff + 1'b1;
         end
      end
      if (cmd.capture) begin
         sum_hold_in = sse_in;
         cnt_hold_in = pair_in;
         arg_in = SumWidth'(pair_in) * SumWidth'(PeakSq);
         pair_in = '0;
         mis_in = '0;
         sse_in = '0;
      end
      if (cmd.log_start) begin
         y_in = {1'b0, norm};
         r_in = LogWidth'(msb) << LogFrac;
         bit_in = 5'(LogFrac - 1);
      end
      if (cmd.log_step) begin
         if (ynext[32]) begin
            y_in = ynext >> 1;
            r_in = r_ff | (LogWidth'(1) << bit_ff);
         end else begin
            y_in = ynext;
         end
         bit_in = bit_ff - 1'b1;
         if (status.log_done && !cmd.log_second) begin
            ln_in = r_in;
            arg_in = sum_hold_ff;
         end
      end
   end

   assign status.log_done = (bit_ff == 5'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff <= '0;
         mis_ff <= '0;
         sse_ff <= '0;
         bit_ff <= '0;
      end else begin
         pair_ff <= pair_in;
         mis_ff <= mis_in;
         sse_ff <= sse_in;
         bit_ff <= bit_in;
      end
      arg_ff <= arg_in;
      sum_hold_ff <= sum_hold_in;
      cnt_hold_ff <= cnt_hold_in;
      y_ff <= y_in;
      r_ff <= r_in;
      ln_ff <= ln_in;
      if (cmd.capture) begin
         byte_count <= pair_in == '0 ? cnt_hold_in : cnt_hold_in;
         mismatch_count <= mis_ff + CountWidth'(cmd.accumulate && (d != 0)
                           && (pair_ff < CountWidth'(MAX_BYTES)));
         squared_error_sum <= sum_hold_in;
         identical <= (sum_hold_in == '0);
      end
      if (cmd.finish) begin
         if (identical || (ln_ff <= r_ff)) begin
            psnr_db_q8 <= '0;
         end else if (q > 17'd32767) begin
            psnr_db_q8 <= '1;
         end else begin
            psnr_db_q8 <= q[PsnrWidth-1:0];
         end
      end
   end
endmodule

// ===== rtl/psnr_ctrl.sv =====
// psnr_ctrl: sequencer for accumulation and the two log2 passes; depends on psnr_pkg
module psnr_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic                      req_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  psnr_pkg::psnr_status_type status,
   output psnr_pkg::psnr_cmd_type    cmd
);
   import psnr_pkg::*;

   typedef enum logic [2:0] {
      ST_ACC, ST_START_N, ST_LOG_N, ST_START_D, ST_LOG_D, ST_FINISH, ST_OUT
   } state_type;

   state_type state_ff;
   logic      take;

   assign req_tready = (state_ff == ST_ACC);
   assign take = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_OUT);

   always_comb begin
      cmd = '0;
      cmd.accumulate = take;
      cmd.capture = take && req_tlast;
      cmd.log_start = (state_ff == ST_START_N) || (state_ff == ST_START_D);
      cmd.log_step = (state_ff == ST_LOG_N) || (state_ff == ST_LOG_D);
      cmd.log_second = (state_ff == ST_LOG_D);
      cmd.finish = (state_ff == ST_FINISH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACC;
      end else begin
         unique case (state_ff)
            ST_ACC:     if (take && req_tlast) state_ff <= ST_START_N;
            ST_START_N: state_ff <= ST_LOG_N;
            ST_LOG_N:   if (status.log_done) state_ff <= ST_START_D;
            ST_START_D: state_ff <= ST_LOG_D;
            ST_LOG_D:   if (status.log_done) state_ff <= ST_FINISH;
            ST_FINISH:  state_ff <= ST_OUT;
            ST_OUT:     if (rsp_tready) state_ff <= ST_ACC;
            default:    state_ff <= ST_ACC;
         endcase
      end
   end
endmodule
